@@ sv/tlb_pkg.sv @@
package tlb_pkg;

  localparam int unsigned PID_W   = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned FRAME_W = 16;
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned PS_W    = 17;
  localparam int unsigned CNT_W   = 5;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_FILL      = 1'b1;

  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  localparam logic [1:0] CFG_ENTRIES   = 2'd0;
  localparam logic [1:0] CFG_POLICY    = 2'd1;
  localparam logic [1:0] CFG_PAGE_SIZE = 2'd2;

  localparam logic [PS_W-1:0] PAGE_SIZE_RST = 17'd32;
  localparam logic [PS_W-1:0] PAGE_SIZE_MAX = 17'd65536;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [PS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quot;
    logic [PS_W-1:0]   rem;
  } div_rsp_t;

endpackage

@@ sv/tlb_div.sv @@
module tlb_div (
  input  logic                clk,
  input  logic                rst_n,
  input  tlb_pkg::div_req_t   req,
  output tlb_pkg::div_rsp_t   rsp
);

  localparam int unsigned AW = tlb_pkg::ADDR_W;
  localparam int unsigned PW = tlb_pkg::PS_W;

  logic              busy_r, busy_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]     q_r, q_nxt;
  logic [PW:0]       rem_r, rem_nxt;
  logic [PW-1:0]     dvs_r, dvs_nxt;
  logic              done_r, done_nxt;
  logic [PW:0]       shifted;
  logic [PW:0]       diff;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[PW-1:0], q_r[AW-1]};
    diff     = shifted - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(AW);
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[PW]) begin
        rem_nxt = diff;
        q_nxt   = {q_r[AW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[AW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r[PW-1:0];

endmodule

@@ sv/tlb_address_translator.sv @@
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_stall   | op, pid, logical_addr, frame
// out_    | output    | out_valid/out_stall | hit, page, offset, frame_out, physical_addr
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// One item at a time. The bit-serial divider splits the address into page
// and offset, then the entry scan and rank update follow (a fill that
// replaces also runs a victim search), then a multiply and the output load;
// the next item is accepted once the result has been loaded.
// Reset (rst_n low, synchronous) empties the buffer; no clearing pass.
// A result waits in the output register while out_stall is high; the next
// item is worked on meanwhile and holds before the load until it frees.
module tlb_address_translator #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [tlb_pkg::PID_W-1:0]     in_pid,
  input  logic [tlb_pkg::ADDR_W-1:0]    in_logical_addr,
  input  logic [tlb_pkg::FRAME_W-1:0]   in_frame,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [tlb_pkg::ADDR_W-1:0]    out_page,
  output logic [tlb_pkg::OFF_W-1:0]     out_offset,
  output logic [tlb_pkg::FRAME_W-1:0]   out_frame_out,
  output logic [tlb_pkg::ADDR_W-1:0]    out_physical_addr,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [tlb_pkg::PS_W-1:0]      cfg_data
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW = tlb_pkg::ADDR_W;
  localparam int unsigned PW = tlb_pkg::PS_W;
  localparam int unsigned FW = tlb_pkg::FRAME_W;
  localparam int unsigned DW = tlb_pkg::PID_W;

  typedef struct packed {
    logic [DW-1:0] pid;
    logic [AW-1:0] page;
    logic [FW-1:0] frame;
    logic [IW-1:0] irank;
    logic [IW-1:0] urank;
  } ent_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_FIND  = 9'b000000100,
    S_FCHK  = 9'b000001000,
    S_VICT  = 9'b000010000,
    S_UPD   = 9'b000100000,
    S_UCHK  = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      lim_r;
  logic               pol_r;
  logic [PW-1:0]      ps_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;

  logic               op_r;
  logic [DW-1:0]      pid_r;
  logic [AW-1:0]      addr_r;
  logic [FW-1:0]      frame_r;
  logic [AW-1:0]      page_r, page_nxt;
  logic [PW-1:0]      off_r, off_nxt;
  logic               hit_r, hit_nxt;
  logic [FW-1:0]      fout_r, fout_nxt;
  logic [IW-1:0]      slot_r, slot_nxt;
  logic               found_r, found_nxt;
  logic [IW-1:0]      ref_r, ref_nxt;
  logic [IW-1:0]      refi_r, refi_nxt;
  logic [IW-1:0]      refu_r, refu_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      phys_r;

  logic                       out_load;
  logic                       ohit_r;
  logic [AW-1:0]              opage_r;
  logic [tlb_pkg::OFF_W-1:0]  ooff_r;
  logic [FW-1:0]              ofout_r;
  logic [AW-1:0]              ophys_r;

  ent_t               mem [MAX_ENTRIES];
  ent_t               rd_r;
  logic [IW-1:0]      raddr;
  logic               we;
  logic [IW-1:0]      waddr;
  ent_t               wdata;

  tlb_pkg::div_req_t  dreq;
  tlb_pkg::div_rsp_t  drsp;
  logic [PW-1:0]      eff_ps;
  logic [CW-1:0]      cfg_lim;

  logic               in_acc, out_acc, cfg_acc;
  logic               vld_r, vld_nxt;

  localparam logic [1:0] M_TOUCH  = 2'd0;
  localparam logic [1:0] M_APPEND = 2'd1;
  localparam logic [1:0] M_REPL   = 2'd2;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_OUT) && (!vld_r || out_acc);

  assign eff_ps  = (ps_r == '0) ? PW'(1) :
                   (ps_r > tlb_pkg::PAGE_SIZE_MAX) ? tlb_pkg::PAGE_SIZE_MAX : ps_r;
  assign cfg_lim = (32'(cfg_data[4:0]) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) :
                   CW'(cfg_data[4:0]);

  assign dreq.start    = in_acc;
  assign dreq.dividend = in_logical_addr;
  assign dreq.divisor  = eff_ps;

  tlb_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    page_nxt  = page_r;
    off_nxt   = off_r;
    hit_nxt   = hit_r;
    fout_nxt  = fout_r;
    slot_nxt  = slot_r;
    found_nxt = found_r;
    ref_nxt   = ref_r;
    refi_nxt  = refi_r;
    refu_nxt  = refu_r;
    mode_nxt  = mode_r;
    idx_nxt   = idx_r;
    vld_nxt   = vld_r;
    raddr     = idx_r[IW-1:0];
    we        = 1'b0;
    waddr     = idx_r[IW-1:0];
    wdata     = rd_r;
    if (out_acc) vld_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (drsp.done) begin
          page_nxt  = drsp.quot;
          off_nxt   = drsp.rem;
          hit_nxt   = (op_r == tlb_pkg::OP_FILL);
          fout_nxt  = (op_r == tlb_pkg::OP_FILL) ? frame_r : '0;
          found_nxt = 1'b0;
          idx_nxt   = '0;
          if (lim_r == '0 || cnt_r == '0) begin
            state_nxt = (op_r == tlb_pkg::OP_FILL && lim_r != '0) ? S_VICT : S_MUL;
            idx_nxt   = '0;
          end else begin
            raddr     = '0;
            state_nxt = S_FIND;
          end
        end
      end
      S_FIND: state_nxt = S_FCHK;
      S_FCHK: begin
        if (rd_r.pid == pid_r && rd_r.page == page_r) begin
          found_nxt = 1'b1;
          slot_nxt  = idx_r[IW-1:0];
          ref_nxt   = rd_r.urank;
          if (op_r == tlb_pkg::OP_TRANSLATE) begin
            hit_nxt  = 1'b1;
            fout_nxt = rd_r.frame;
          end
          mode_nxt  = M_TOUCH;
          idx_nxt   = '0;
          raddr     = '0;
          state_nxt = S_UPD;
        end else if (idx_r + CW'(1) == cnt_r) begin
          if (op_r == tlb_pkg::OP_FILL) begin
            idx_nxt   = '0;
            raddr     = '0;
            state_nxt = S_VICT;
          end else begin
            state_nxt = S_MUL;
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          raddr     = idx_nxt[IW-1:0];
          state_nxt = S_FIND;
        end
      end
      S_VICT: begin
        if (cnt_r < lim_r) begin
          mode_nxt  = M_APPEND;
          slot_nxt  = cnt_r[IW-1:0];
          cnt_nxt   = cnt_r + CW'(1);
          idx_nxt   = '0;
          raddr     = '0;
          state_nxt = S_UPD;
        end else if (!found_r) begin
          // first pass of victim search reuses the read pipe
          found_nxt = 1'b1;
          idx_nxt   = '0;
          raddr     = '0;
        end else begin
          if (((pol_r == tlb_pkg::POL_LRU) ? rd_r.urank : rd_r.irank)
              == IW'(cnt_r - CW'(1))) begin
            slot_nxt = idx_r[IW-1:0];
            refi_nxt = rd_r.irank;
            refu_nxt = rd_r.urank;
          end
          if (idx_r + CW'(1) == cnt_r) begin
            mode_nxt  = M_REPL;
            found_nxt = 1'b0;
            idx_nxt   = '0;
            raddr     = '0;
            state_nxt = S_UPD;
          end else begin
            idx_nxt = idx_r + CW'(1);
            raddr   = idx_nxt[IW-1:0];
          end
        end
      end
      S_UPD: state_nxt = S_UCHK;
      S_UCHK: begin
        we    = 1'b1;
        wdata = rd_r;
        if (idx_r[IW-1:0] == slot_r) begin
          wdata.urank = '0;
          if (mode_r == M_TOUCH) begin
            if (op_r == tlb_pkg::OP_FILL) wdata.frame = frame_r;
          end else begin
            wdata.pid   = pid_r;
            wdata.page  = page_r;
            wdata.frame = frame_r;
            wdata.irank = '0;
          end
        end else begin
          unique case (mode_r)
            M_TOUCH: if (rd_r.urank < ref_r) wdata.urank = rd_r.urank + IW'(1);
            M_APPEND: begin
              wdata.urank = rd_r.urank + IW'(1);
              wdata.irank = rd_r.irank + IW'(1);
            end
            default: begin
              if (rd_r.urank < refu_r) wdata.urank = rd_r.urank + IW'(1);
              if (rd_r.irank < refi_r) wdata.irank = rd_r.irank + IW'(1);
            end
          endcase
        end
        if (idx_r + CW'(1) == cnt_r) begin
          state_nxt = S_MUL;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          raddr     = idx_nxt[IW-1:0];
          state_nxt = S_UPD;
        end
      end
      S_MUL: state_nxt = S_OUT;
      S_OUT: begin
        if (!vld_r || out_acc) begin
          vld_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_acc && cfg_index == tlb_pkg::CFG_ENTRIES) cnt_nxt = '0;
  end

  // S_VICT with found_r set on entry is the scan phase; clear flag on entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= 1'b0;
      cnt_r   <= '0;
      lim_r   <= '0;
      pol_r   <= tlb_pkg::POL_FIFO;
      ps_r    <= tlb_pkg::PAGE_SIZE_RST;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_acc) begin
        unique case (cfg_index)
          tlb_pkg::CFG_ENTRIES:   lim_r <= cfg_lim;
          tlb_pkg::CFG_POLICY:    pol_r <= cfg_data[0];
          tlb_pkg::CFG_PAGE_SIZE: ps_r  <= cfg_data;
          default: ;
        endcase
      end
    end
    if (in_acc) begin
      op_r    <= in_op;
      pid_r   <= in_pid;
      addr_r  <= in_logical_addr;
      frame_r <= in_frame;
    end
    page_r  <= page_nxt;
    off_r   <= off_nxt;
    hit_r   <= hit_nxt;
    fout_r  <= fout_nxt;
    slot_r  <= slot_nxt;
    found_r <= (state_r == S_FCHK && state_nxt == S_VICT) ? 1'b0 : found_nxt;
    ref_r   <= ref_nxt;
    refi_r  <= refi_nxt;
    refu_r  <= refu_nxt;
    mode_r  <= mode_nxt;
    idx_r   <= idx_nxt;
    if (state_r == S_MUL) begin
      phys_r <= hit_r ? AW'(32'(fout_r) * 32'(eff_ps) + 32'(off_r)) : '0;
    end
    if (out_load) begin
      ohit_r  <= hit_r;
      opage_r <= page_r;
      ooff_r  <= off_r[tlb_pkg::OFF_W-1:0];
      ofout_r <= fout_r;
      ophys_r <= phys_r;
    end
  end

  assign out_valid         = vld_r;
  assign out_hit           = ohit_r;
  assign out_page          = opage_r;
  assign out_offset        = ooff_r;
  assign out_frame_out     = ofout_r;
  assign out_physical_addr = ophys_r;

`ifndef SYNTHESIS
  a_cnt_lim: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lim_r) else $error("entry count above limit");
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_DIV) else $error("accept did not start split");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_physical_addr == '0 && out_frame_out == '0)
    else $error("miss carries data");
  a_addr_kept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE && !in_acc |=> $stable(addr_r)) else $error("item lost");
`endif

endmodule

@@ sim/tb_tlb_address_translator.sv @@
`timescale 1ns / 100ps

module tb_tlb_address_translator;

  localparam int NSLOT = 16;
  localparam int PID_W   = tlb_pkg::PID_W;
  localparam int ADDR_W  = tlb_pkg::ADDR_W;
  localparam int FRAME_W = tlb_pkg::FRAME_W;
  localparam int OFF_W   = tlb_pkg::OFF_W;
  localparam int PS_W    = tlb_pkg::PS_W;
  localparam int CNT_W   = tlb_pkg::CNT_W;

  typedef struct {
    logic               op;
    logic [PID_W-1:0]   pid;
    logic [ADDR_W-1:0]  addr;
    logic [FRAME_W-1:0] frame;
  } xlat_item_t;

  typedef struct {
    logic               hit;
    logic [ADDR_W-1:0]  page;
    logic [OFF_W-1:0]   offset;
    logic [FRAME_W-1:0] frame_out;
    logic [ADDR_W-1:0]  phys;
  } xlat_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = tlb_pkg::OP_TRANSLATE;
  logic [PID_W-1:0] in_pid = '0;
  logic [ADDR_W-1:0] in_logical_addr = '0;
  logic [FRAME_W-1:0] in_frame = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [ADDR_W-1:0] out_page;
  logic [OFF_W-1:0] out_offset;
  logic [FRAME_W-1:0] out_frame_out;
  logic [ADDR_W-1:0] out_physical_addr;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = tlb_pkg::CFG_ENTRIES;
  logic [PS_W-1:0] cfg_data = '0;

  tlb_address_translator u_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [CNT_W-1:0]   m_entries;
  logic               m_policy;
  logic [PS_W-1:0]    m_page_size;
  logic               m_valid [NSLOT];
  logic [PID_W-1:0]   m_pid [NSLOT];
  logic [ADDR_W-1:0]  m_page [NSLOT];
  logic [FRAME_W-1:0] m_frame [NSLOT];
  int unsigned        m_ins_rank [NSLOT];
  int unsigned        m_use_rank [NSLOT];
  int unsigned        m_count;

  xlat_item_t   pending_items[$];
  xlat_result_t expected_results[$];
  int  errors = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_hits = 0;
  bit  busy = 1'b0;
  bit  quiet = 1'b0;
  bit  press_req = 1'b0;
  int  gap = 0;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] eff_page_size();
    if (m_page_size == '0) return ADDR_W'(1);
    if (m_page_size > tlb_pkg::PAGE_SIZE_MAX) return ADDR_W'(tlb_pkg::PAGE_SIZE_MAX);
    return ADDR_W'(m_page_size);
  endfunction

  function automatic int unsigned entry_limit();
    return (m_entries > NSLOT) ? NSLOT : 32'(m_entries);
  endfunction

  function automatic void flush_tlb();
    for (int i = 0; i < NSLOT; i++) begin
      m_valid[i] = 1'b0;
      m_ins_rank[i] = 0;
      m_use_rank[i] = 0;
    end
    m_count = 0;
  endfunction

  function automatic int lookup_slot(logic [PID_W-1:0] pid, logic [ADDR_W-1:0] page);
    for (int i = 0; i < m_count; i++)
      if (m_valid[i] && m_pid[i] == pid && m_page[i] == page) return i;
    return -1;
  endfunction

  function automatic void mark_used(int s);
    int unsigned r;
    r = m_use_rank[s];
    for (int i = 0; i < m_count; i++)
      if (m_use_rank[i] < r) m_use_rank[i]++;
    m_use_rank[s] = 0;
  endfunction

  function automatic void install_entry(logic [PID_W-1:0] pid, logic [ADDR_W-1:0] page,
                                        logic [FRAME_W-1:0] frame);
    int s;
    int victim;
    int unsigned r;
    victim = 0;
    if (entry_limit() == 0) return;
    s = lookup_slot(pid, page);
    if (s >= 0) begin
      m_frame[s] = frame;
      mark_used(s);
      return;
    end
    if (m_count < entry_limit()) begin
      victim = int'(m_count);
      m_count++;
      for (int i = 0; i < m_count; i++) begin
        m_ins_rank[i]++;
        m_use_rank[i]++;
      end
    end else begin
      for (int i = 0; i < m_count; i++) begin
        r = (m_policy == tlb_pkg::POL_LRU) ? m_use_rank[i] : m_ins_rank[i];
        if (r == m_count - 1) victim = i;
      end
      for (int i = 0; i < m_count; i++) begin
        if (m_ins_rank[i] < m_ins_rank[victim]) m_ins_rank[i]++;
        if (m_use_rank[i] < m_use_rank[victim]) m_use_rank[i]++;
      end
    end
    m_valid[victim] = 1'b1;
    m_pid[victim] = pid;
    m_page[victim] = page;
    m_frame[victim] = frame;
    m_ins_rank[victim] = 0;
    m_use_rank[victim] = 0;
  endfunction

  function automatic void translate_item(xlat_item_t it);
    xlat_result_t res;
    logic [ADDR_W-1:0] ps;
    int s;
    ps = eff_page_size();
    res.page = it.addr / ps;
    res.offset = OFF_W'(it.addr % ps);
    res.hit = 1'b0;
    res.frame_out = '0;
    if (it.op == tlb_pkg::OP_TRANSLATE) begin
      s = (entry_limit() == 0) ? -1 : lookup_slot(it.pid, res.page);
      if (s >= 0) begin
        res.hit = 1'b1;
        res.frame_out = m_frame[s];
        mark_used(s);
      end
    end else begin
      res.hit = 1'b1;
      res.frame_out = it.frame;
      install_entry(it.pid, res.page, it.frame);
    end
    res.phys = res.hit ? ADDR_W'(ADDR_W'(res.frame_out) * ps + ADDR_W'(res.offset)) : '0;
    expected_results.push_back(res);
  endfunction

  task automatic report(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    $display("MISMATCH %s at %0t: got %0h expected %0h", what, $time, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    xlat_item_t it;
    if (!rst_n) begin
      busy = 1'b0;
      gap = 0;
    end else begin
      if (busy && !in_stall) begin
        it.op = in_op;
        it.pid = in_pid;
        it.addr = in_logical_addr;
        it.frame = in_frame;
        translate_item(it);
        n_items++;
        busy = 1'b0;
        gap = rand_gap();
      end
      if (!busy) begin
        if (gap > 0) gap--;
        else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_op <= it.op;
          in_pid <= it.pid;
          in_logical_addr <= it.addr;
          in_frame <= it.frame;
          busy = 1'b1;
        end
      end
    end
    in_valid <= busy;
  end

  // monitor
  always @(posedge clk) begin
    xlat_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_results.size() == 0) begin
        report("unexpected item", out_page, '0);
      end else begin
        e = expected_results.pop_front();
        if (out_hit) n_hits++;
        if (out_hit !== e.hit) report("hit", ADDR_W'(out_hit), ADDR_W'(e.hit));
        if (out_page !== e.page) report("page", out_page, e.page);
        if (out_offset !== e.offset)
          report("offset", ADDR_W'(out_offset), ADDR_W'(e.offset));
        if (out_frame_out !== e.frame_out)
          report("frame_out", ADDR_W'(out_frame_out), ADDR_W'(e.frame_out));
        if (out_physical_addr !== e.phys) report("physical_addr", out_physical_addr, e.phys);
      end
    end
  end

  // receiver back-pressure, with one long hold-off on request
  int  stall_left = 0;
  bit  press_done = 1'b0;
  always @(posedge clk) begin
    if (press_req && !press_done) begin
      press_done = 1'b1;
      stall_left = 600;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = rand_gap();
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [PS_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tlb_pkg::CFG_ENTRIES: begin
        m_entries = data[CNT_W-1:0];
        flush_tlb();
      end
      tlb_pkg::CFG_POLICY: m_policy = data[0];
      tlb_pkg::CFG_PAGE_SIZE: m_page_size = data;
      default: ;
    endcase
  endtask

  task automatic configure(logic [CNT_W-1:0] ent, logic pol, logic [PS_W-1:0] ps);
    cfg_write(tlb_pkg::CFG_ENTRIES, PS_W'(ent));
    cfg_write(tlb_pkg::CFG_POLICY, PS_W'(pol));
    cfg_write(tlb_pkg::CFG_PAGE_SIZE, ps);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic push(logic op, logic [PID_W-1:0] pid, logic [ADDR_W-1:0] addr,
                      logic [FRAME_W-1:0] frame);
    xlat_item_t it;
    it.op = op;
    it.pid = pid;
    it.addr = addr;
    it.frame = frame;
    pending_items.push_back(it);
  endtask

  // mostly translate/fill over a small key pool so hits and evictions happen
  task automatic push_random(int count);
    logic [PID_W-1:0] pids [3];
    logic [ADDR_W-1:0] ps;
    logic [ADDR_W-1:0] addr;
    int r;
    ps = eff_page_size();
    for (int i = 0; i < 3; i++) pids[i] = PID_W'($urandom);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      addr = ADDR_W'($urandom_range(0, 9) * ps + $urandom_range(0, ps - 1));
      if (r < 45)
        push(tlb_pkg::OP_TRANSLATE, pids[$urandom_range(0, 2)], addr, FRAME_W'($urandom));
      else if (r < 80)
        push(tlb_pkg::OP_FILL, pids[$urandom_range(0, 2)], addr, FRAME_W'($urandom));
      else
        push(1'($urandom), PID_W'($urandom), ADDR_W'($urandom), FRAME_W'($urandom));
    end
  endtask

  initial begin
    m_entries = '0;
    m_policy = tlb_pkg::POL_FIFO;
    m_page_size = tlb_pkg::PAGE_SIZE_RST;
    flush_tlb();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: buffer disabled
    push(tlb_pkg::OP_FILL, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push(tlb_pkg::OP_TRANSLATE, 16'hFFFF, 32'hFFFF_FFFF, 16'h0);
    wait_drained();

    // FIFO with four entries
    configure(5'd4, tlb_pkg::POL_FIFO, 17'd32);
    push(tlb_pkg::OP_FILL, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push(tlb_pkg::OP_TRANSLATE, 16'hFFFF, 32'hFFFF_FFE0, 16'h0);
    push(tlb_pkg::OP_TRANSLATE, 16'h0, 32'h0, 16'h0);
    push(tlb_pkg::OP_FILL, 16'h0, 32'h0, 16'h1);
    push(tlb_pkg::OP_FILL, 16'h0, 32'h20, 16'h2);
    push(tlb_pkg::OP_FILL, 16'h0, 32'h40, 16'h3);
    push(tlb_pkg::OP_TRANSLATE, 16'hFFFF, 32'hFFFF_FFFF, 16'h0);
    push(tlb_pkg::OP_FILL, 16'h0, 32'h5, 16'h7);
    push(tlb_pkg::OP_FILL, 16'h0, 32'h60, 16'h4);
    push(tlb_pkg::OP_TRANSLATE, 16'hFFFF, 32'hFFFF_FFFF, 16'h0);
    push(tlb_pkg::OP_TRANSLATE, 16'h0, 32'h1F, 16'h0);
    wait_drained();

    // LRU, then page size zero and above the maximum
    configure(5'd2, tlb_pkg::POL_LRU, 17'd0);
    push(tlb_pkg::OP_FILL, 16'h1, 32'h10, 16'hA);
    push(tlb_pkg::OP_FILL, 16'h1, 32'h11, 16'hB);
    push(tlb_pkg::OP_TRANSLATE, 16'h1, 32'h10, 16'h0);
    push(tlb_pkg::OP_FILL, 16'h1, 32'h12, 16'hC);
    push(tlb_pkg::OP_TRANSLATE, 16'h1, 32'h11, 16'h0);
    push(tlb_pkg::OP_TRANSLATE, 16'h1, 32'h10, 16'h0);
    wait_drained();
    configure(5'd31, tlb_pkg::POL_FIFO, 17'h1FFFF);
    push(tlb_pkg::OP_FILL, 16'h5, 32'hFFFF_FFFF, 16'hFFFF);
    push(tlb_pkg::OP_TRANSLATE, 16'h5, 32'hFFFF_0000, 16'h0);
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      logic [CNT_W-1:0] ent;
      logic [PS_W-1:0] ps;
      case (ph % 9)
        0: begin ent = 5'd16; ps = 17'd65536; end
        1: begin ent = 5'd1;  ps = 17'd1; end
        2: begin ent = 5'd0;  ps = 17'd32; end
        3: begin ent = 5'd31; ps = 17'h1FFFF; end
        4: begin ent = 5'd16; ps = 17'd0; end
        default: begin
          ent = CNT_W'($urandom_range(0, 31));
          ps = PS_W'($urandom_range(0, 131071));
        end
      endcase
      quiet = (ph == 2 || ph == 6);
      configure(ent, 1'($urandom), ps);
      if (ph == 3) press_req = 1'b1;
      push_random(52);
      wait_drained();
    end

    $display("Covered %0d items, %0d results, %0d hits, FIFO and LRU policies,",
             n_items, n_results, n_hits);
    $display("entry limits 0 to 31 and page sizes 0 to 131071.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout at %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

endmodule
